// File: src/axis_frame_builder_assert.svh
// Assertion macros for the frame builder.
`ifndef AXIS_FRAME_BUILDER_ASSERT_SVH
`define AXIS_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AFB_IMPLIES(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AFB_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: src/afb_pkg.sv
package afb_pkg;

	localparam int FRAC = 30;
	localparam int MAGW = 30;
	localparam int QW   = 31;
	localparam int OUTW = 32;
	localparam int SUMW = 62;
	localparam int NUMW = 61;

	function automatic int norm_word(input int iw);
		return (iw < 32) ? 32 : iw;
	endfunction

	// cycles from vector in to unit vector out
	function automatic int norm_lat(input int iw);
		return 5 + 2 * QW + $clog2(norm_word(iw));
	endfunction

endpackage

// File: src/axis_frame_builder.sv
// Builds an orthonormal frame (dir, side, third; signed Q2.30) from two Q16.16 points.
// Fully pipelined: one item per cycle while the output is not held; three normalizer
// passes run in series, each built from bit-per-stage square root and divider chains.
// The whole pipe stalls together when the output transfer is held; degenerate marks
// coinciding points, axes then zero.
`include "axis_frame_builder_assert.svh"
module axis_frame_builder
	import afb_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	output logic                          frame_valid,
	input  logic                          frame_ready,
	output logic signed [OUTW-1:0]        dir_x,
	output logic signed [OUTW-1:0]        dir_y,
	output logic signed [OUTW-1:0]        dir_z,
	output logic signed [OUTW-1:0]        side_x,
	output logic signed [OUTW-1:0]        side_y,
	output logic signed [OUTW-1:0]        side_z,
	output logic signed [OUTW-1:0]        third_x,
	output logic signed [OUTW-1:0]        third_y,
	output logic signed [OUTW-1:0]        third_z,
	output logic                          degenerate
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * OUTW;
	localparam int LA = norm_lat(DW);
	localparam int LB = norm_lat(OUTW);
	localparam int LC = norm_lat(PW);

	typedef struct packed {
		logic v;
		logic hx;
		logic deg;
	} sa_t;

	typedef struct packed {
		logic                 v;
		logic                 deg;
		logic [2:0][OUTW-1:0] dir;
	} sb_t;

	typedef struct packed {
		logic                 v;
		logic                 deg;
		logic [2:0][OUTW-1:0] dir;
		logic [2:0][OUTW-1:0] side;
	} sc_t;

	typedef struct packed {
		logic                 v;
		logic                 deg;
		logic [2:0][OUTW-1:0] dir;
		logic [2:0][OUTW-1:0] side;
		logic [2:0][OUTW-1:0] third;
	} frame_t;

	logic   adv;
	frame_t frm_q;

	assign adv        = !frm_q.v || frame_ready;
	assign item_ready = adv;

	// difference
	logic              v_s1;
	logic [2:0][DW-1:0] d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= DW'(end_x) - DW'(start_x);
			d_s1[1] <= DW'(end_y) - DW'(start_y);
			d_s1[2] <= DW'(end_z) - DW'(start_z);
		end
	end

	// helper choice and degenerate test ride alongside the first normalizer
	logic [DW-1:0] ax;
	logic [DW-1:0] ay;
	sa_t           pa0;
	sa_t           pa_s [1:LA];

	always_comb begin
		ax      = d_s1[0][DW-1] ? (~d_s1[0] + DW'(1)) : d_s1[0];
		ay      = d_s1[1][DW-1] ? (~d_s1[1] + DW'(1)) : d_s1[1];
		pa0.v   = v_s1;
		pa0.hx  = (ax > ay);
		pa0.deg = (d_s1 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LA; k++) begin
				pa_s[k] <= '0;
			end
		end else if (adv) begin
			pa_s[1] <= pa0;
			for (int k = 1; k < LA; k++) begin
				pa_s[k+1] <= pa_s[k];
			end
		end
	end

	logic [2:0][OUTW-1:0] dir_u;

	afb_norm #(.IW(DW)) u_norm_dir (
		.clk  (clk),
		.adv  (adv),
		.vec  (d_s1),
		.unit (dir_u)
	);

	// helper cross dir
	logic [2:0][OUTW-1:0] s_s;
	sb_t                  pb_s [0:LB];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pa_s[LA].hx) begin
				s_s[0] <= dir_u[2];
				s_s[1] <= '0;
				s_s[2] <= ~dir_u[0] + OUTW'(1);
			end else begin
				s_s[0] <= '0;
				s_s[1] <= ~dir_u[2] + OUTW'(1);
				s_s[2] <= dir_u[1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LB; k++) begin
				pb_s[k] <= '0;
			end
		end else if (adv) begin
			pb_s[0].v   <= pa_s[LA].v;
			pb_s[0].deg <= pa_s[LA].deg;
			pb_s[0].dir <= dir_u;
			for (int k = 0; k < LB; k++) begin
				pb_s[k+1] <= pb_s[k];
			end
		end
	end

	logic [2:0][OUTW-1:0] side_u;

	afb_norm #(.IW(OUTW)) u_norm_side (
		.clk  (clk),
		.adv  (adv),
		.vec  (s_s),
		.unit (side_u)
	);

	// dir cross side, exact in Q4.60
	logic signed [PW-1:0] prod [6];
	logic [5:0][PW-1:0]   pp_s;
	sc_t                  pp_c_s;

	always_comb begin
		prod[0] = $signed(pb_s[LB].dir[1]) * $signed(side_u[2]);
		prod[1] = $signed(pb_s[LB].dir[2]) * $signed(side_u[1]);
		prod[2] = $signed(pb_s[LB].dir[2]) * $signed(side_u[0]);
		prod[3] = $signed(pb_s[LB].dir[0]) * $signed(side_u[2]);
		prod[4] = $signed(pb_s[LB].dir[0]) * $signed(side_u[1]);
		prod[5] = $signed(pb_s[LB].dir[1]) * $signed(side_u[0]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 6; i++) begin
				pp_s[i] <= prod[i];
			end
		end
	end

	logic [2:0][PW-1:0] c_s;
	sc_t                pc_s [0:LC];

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s[0] <= pp_s[0] - pp_s[1];
			c_s[1] <= pp_s[2] - pp_s[3];
			c_s[2] <= pp_s[4] - pp_s[5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_c_s <= '0;
			for (int k = 0; k <= LC; k++) begin
				pc_s[k] <= '0;
			end
		end else if (adv) begin
			pp_c_s.v    <= pb_s[LB].v;
			pp_c_s.deg  <= pb_s[LB].deg;
			pp_c_s.dir  <= pb_s[LB].dir;
			pp_c_s.side <= side_u;
			pc_s[0]     <= pp_c_s;
			for (int k = 0; k < LC; k++) begin
				pc_s[k+1] <= pc_s[k];
			end
		end
	end

	logic [2:0][OUTW-1:0] third_u;

	afb_norm #(.IW(PW)) u_norm_third (
		.clk  (clk),
		.adv  (adv),
		.vec  (c_s),
		.unit (third_u)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_q <= '0;
		end else if (adv) begin
			frm_q.v   <= pc_s[LC].v;
			frm_q.deg <= pc_s[LC].deg;
			if (pc_s[LC].deg) begin
				frm_q.dir   <= '0;
				frm_q.side  <= '0;
				frm_q.third <= '0;
			end else begin
				frm_q.dir   <= pc_s[LC].dir;
				frm_q.side  <= pc_s[LC].side;
				frm_q.third <= third_u;
			end
		end
	end

	assign frame_valid = frm_q.v;
	assign degenerate  = frm_q.deg;
	assign dir_x       = frm_q.dir[0];
	assign dir_y       = frm_q.dir[1];
	assign dir_z       = frm_q.dir[2];
	assign side_x      = frm_q.side[0];
	assign side_y      = frm_q.side[1];
	assign side_z      = frm_q.side[2];
	assign third_x     = frm_q.third[0];
	assign third_y     = frm_q.third[1];
	assign third_z     = frm_q.third[2];

	`AFB_IMPLIES(a_degen_zero, frame_valid && degenerate, dir_x == '0 && dir_y == '0 && dir_z == '0 && side_x == '0 && third_x == '0, "degenerate frame with nonzero axes")
	`AFB_IMPLIES(a_dir_range, frame_valid && !degenerate, dir_x <= 32'sd1073741824 && dir_x >= -32'sd1073741824, "dir_x beyond unit range")
	`AFB_NEXT(a_hold_valid, frame_valid && !frame_ready, frame_valid, "frame dropped while stalled")

endmodule

// File: src/afb_norm.sv
module afb_norm
	import afb_pkg::*;
#(
	parameter int IW = 33
) (
	input  logic                  clk,
	input  logic                  adv,
	input  logic [2:0][IW-1:0]    vec,
	output logic [2:0][OUTW-1:0]  unit
);

	localparam int W   = norm_word(IW);
	localparam int K   = $clog2(W);
	localparam int TW  = SUMW + 1;
	localparam int DTW = NUMW + 1;

	typedef struct packed {
		logic [2:0]           neg;
		logic                 zero;
		logic [2:0][MAGW-1:0] mag;
	} carry_t;

	// sign and magnitude
	logic [2:0][IW-1:0] abs_v;
	logic [2:0]         neg_s1;
	logic [2:0][W-1:0]  mag_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_v[i] = vec[i][IW-1] ? (~vec[i] + IW'(1)) : vec[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][IW-1];
				mag_s1[i] <= W'(abs_v[i]);
			end
		end
	end

	// common left shift, largest magnitude to the top bit
	logic [2:0][W-1:0] sh_mag_s [1:K];
	logic [2:0]        sh_neg_s [1:K];

	for (genvar k = 0; k < K; k++) begin : g_sh
		localparam int SH = 1 << (K - 1 - k);
		logic [2:0][W-1:0] src;
		logic [2:0]        src_neg;
		logic [W-1:0]      any;
		logic              hit;
		if (k == 0) begin : g_first
			assign src     = mag_s1;
			assign src_neg = neg_s1;
		end else begin : g_next
			assign src     = sh_mag_s[k];
			assign src_neg = sh_neg_s[k];
		end
		assign any = src[0] | src[1] | src[2];
		assign hit = (any[W-1 -: SH] == '0);
		always_ff @(posedge clk) begin
			if (adv) begin
				sh_neg_s[k+1] <= src_neg;
				for (int i = 0; i < 3; i++) begin
					sh_mag_s[k+1][i] <= hit ? (src[i] << SH) : src[i];
				end
			end
		end
	end

	logic [2:0][MAGW-1:0] m30;
	logic                 is_zero;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m30[i] = sh_mag_s[K][i][W-1 -: MAGW];
		end
		is_zero = ~(sh_mag_s[K][0][W-1] | sh_mag_s[K][1][W-1] | sh_mag_s[K][2][W-1]);
	end

	// squares, then sum
	carry_t                 sq_c_s;
	logic [2:0][2*MAGW-1:0] sq_s;
	carry_t                 sum_c_s;
	logic [SUMW-1:0]        sum_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_c_s.neg  <= sh_neg_s[K];
			sq_c_s.zero <= is_zero;
			sq_c_s.mag  <= m30;
			for (int i = 0; i < 3; i++) begin
				sq_s[i] <= m30[i] * m30[i];
			end
			sum_c_s <= sq_c_s;
			sum_s   <= SUMW'(sq_s[0]) + SUMW'(sq_s[1]) + SUMW'(sq_s[2]);
		end
	end

	// square root, one result bit per stage
	logic [SUMW-1:0] rt_rem_s  [1:QW];
	logic [QW-1:0]   rt_root_s [1:QW];
	carry_t          rt_c_s    [1:QW];

	for (genvar g = 0; g < QW; g++) begin : g_rt
		localparam int B = QW - 1 - g;
		logic [SUMW-1:0] rem_in;
		logic [QW-1:0]   root_in;
		carry_t          c_in;
		logic [TW-1:0]   trial;
		logic            ge;
		if (g == 0) begin : g_first
			assign rem_in  = sum_s;
			assign root_in = '0;
			assign c_in    = sum_c_s;
		end else begin : g_next
			assign rem_in  = rt_rem_s[g];
			assign root_in = rt_root_s[g];
			assign c_in    = rt_c_s[g];
		end
		assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
		assign ge    = ({1'b0, rem_in} >= trial);
		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rem_s[g+1]  <= ge ? SUMW'({1'b0, rem_in} - trial) : rem_in;
				rt_root_s[g+1] <= ge ? (root_in | (QW'(1) << B)) : root_in;
				rt_c_s[g+1]    <= c_in;
			end
		end
	end

	// rounded numerators
	logic [2:0][NUMW-1:0] num_s;
	logic [QW-1:0]        num_l_s;
	carry_t               num_c_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				num_s[i] <= (NUMW'(rt_c_s[QW].mag[i]) << FRAC) + NUMW'(rt_root_s[QW] >> 1);
			end
			num_l_s <= rt_root_s[QW];
			num_c_s <= rt_c_s[QW];
		end
	end

	// three dividers, one quotient bit per stage
	logic [2:0][NUMW-1:0] dv_rem_s [1:QW];
	logic [2:0][QW-1:0]   dv_q_s   [1:QW];
	logic [QW-1:0]        dv_l_s   [1:QW];
	carry_t               dv_c_s   [1:QW];

	for (genvar g = 0; g < QW; g++) begin : g_dv
		localparam int B = QW - 1 - g;
		logic [2:0][NUMW-1:0] rem_in;
		logic [2:0][QW-1:0]   q_in;
		logic [QW-1:0]        l_in;
		carry_t               c_in;
		logic [DTW-1:0]       dd;
		logic [2:0]           ge;
		if (g == 0) begin : g_first
			assign rem_in = num_s;
			assign q_in   = '0;
			assign l_in   = num_l_s;
			assign c_in   = num_c_s;
		end else begin : g_next
			assign rem_in = dv_rem_s[g];
			assign q_in   = dv_q_s[g];
			assign l_in   = dv_l_s[g];
			assign c_in   = dv_c_s[g];
		end
		assign dd = DTW'(l_in) << B;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i] = ({1'b0, rem_in[i]} >= dd);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[g+1][i] <= ge[i] ? NUMW'({1'b0, rem_in[i]} - dd) : rem_in[i];
					dv_q_s[g+1][i]   <= ge[i] ? (q_in[i] | (QW'(1) << B)) : q_in[i];
				end
				dv_l_s[g+1] <= l_in;
				dv_c_s[g+1] <= c_in;
			end
		end
	end

	// apply signs
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_c_s[QW].zero) begin
					unit[i] <= '0;
				end else if (dv_c_s[QW].neg[i]) begin
					unit[i] <= ~OUTW'(dv_q_s[QW][i]) + OUTW'(1);
				end else begin
					unit[i] <= OUTW'(dv_q_s[QW][i]);
				end
			end
		end
	end

endmodule
